FILE: rtl/core/pcls_pkg.sv
package pcls_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int QNUM_W = DATA_W + FRAC_W;
    localparam int UDATA_W = DATA_W - 1;
    localparam int IDX_W = 3;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [UDATA_W-1:0] uword_t;
    typedef logic [PROD_W-1:0] prod_t;

    localparam prod_t POS_LIM = {{(PROD_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam prod_t NEG_LIM = POS_LIM + prod_t'(1);
    localparam word_t WORD_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_INITIAL = 3'd0,
        REG_TARGET  = 3'd1,
        REG_GAIN_P  = 3'd2,
        REG_GAIN_I  = 3'd3,
        REG_GAIN_D  = 3'd4,
        REG_STEP    = 3'd5,
        REG_TOL     = 3'd6
    } reg_idx_t;

    localparam word_t  RST_INITIAL = word_t'(0);
    localparam word_t  RST_TARGET  = word_t'(655360);
    localparam word_t  RST_GAIN_P  = word_t'(6554);
    localparam word_t  RST_GAIN_I  = word_t'(6554);
    localparam word_t  RST_GAIN_D  = word_t'(6554);
    localparam uword_t RST_STEP    = uword_t'(6554);
    localparam uword_t RST_TOL     = uword_t'(655);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HOLD,
        OP_ERR,
        OP_DIFF,
        OP_MUL_EDT,
        OP_ACC_ESUM,
        OP_MUL_P,
        OP_ACC_P,
        OP_MUL_I,
        OP_ACC_I,
        OP_MUL_D,
        OP_ACC_D,
        OP_UPDATE,
        OP_CAPTURE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic settled;
        logic div_busy;
    } dp_status_t;

    function automatic word_t mag(input word_t a);
        mag = a[DATA_W-1] ? word_t'(-a) : a;
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            sat_add = s[DATA_W] ? WORD_MIN : WORD_MAX;
        else
            sat_add = s[DATA_W-1:0];
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            sat_sub = s[DATA_W] ? WORD_MIN : WORD_MAX;
        else
            sat_sub = s[DATA_W-1:0];
    endfunction

    // signed result from magnitude and sign, clipped to the word range
    function automatic word_t sat_mag(input prod_t m, input logic neg);
        if (neg) begin
            if (m > NEG_LIM)
                sat_mag = WORD_MIN;
            else
                sat_mag = word_t'(-m[DATA_W-1:0]);
        end
        else begin
            if (m > POS_LIM)
                sat_mag = WORD_MAX;
            else
                sat_mag = m[DATA_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/core/pid_closed_loop_step.sv
// Sequence: a restart or settled request goes from accept through the check and capture
// states to result valid; a full step also waits on the radix-2 divider for the slope.
// Throughput: one request at a time; the next is accepted the cycle after the result
// is registered, and capture waits while a pending result is stalled.
// Reset (rst_n, async low): registers to defaults, plant, integral and last error
// cleared, no result pending.
module pid_closed_loop_step
    import pcls_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    output logic                     tick_stall,
    input  logic                     restart,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] plant_out,
    output logic signed [DATA_W-1:0] offset_out,
    output logic signed [DATA_W-1:0] slope_out,
    output logic signed [DATA_W-1:0] drive_out,
    output logic                     settled,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pcls_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .restart      (restart),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    pcls_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .plant_q   (plant_out),
        .offset_q  (offset_out),
        .slope_q   (slope_out),
        .drive_q   (drive_out),
        .settled_q (settled)
    );

endmodule

FILE: rtl/core/pcls_div.sv
module pcls_div
    import pcls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  word_t  num_mag,
    input  logic   num_neg,
    input  uword_t divisor,
    output logic   busy,
    output word_t  quot
);

    localparam int CNT_W = $clog2(QNUM_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [QNUM_W-1:0] num_reg;
    logic [QNUM_W-1:0] q_reg;
    uword_t            rem_reg;
    uword_t            dvs_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [UDATA_W:0]  rem_sh;
    logic [UDATA_W:0]  rem_dif;
    logic              ge;

    assign rem_sh  = {rem_reg, num_reg[QNUM_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QNUM_W);
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            num_reg  <= {num_mag, {FRAC_W{1'b0}}};
            q_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            neg_reg  <= num_neg;
            zero_reg <= (num_mag == '0);
        end
        else if (busy_reg) begin
            num_reg <= {num_reg[QNUM_W-2:0], 1'b0};
            q_reg   <= {q_reg[QNUM_W-2:0], ge};
            rem_reg <= ge ? rem_dif[UDATA_W-1:0] : rem_sh[UDATA_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = zero_reg ? '0
                : sat_mag({{(PROD_W - QNUM_W){1'b0}}, q_reg}, neg_reg);

endmodule

FILE: rtl/core/pcls_dp.sv
module pcls_dp
    import pcls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]   cfg_data,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output word_t               plant_q,
    output word_t               offset_q,
    output word_t               slope_q,
    output word_t               drive_q,
    output logic                settled_q
);

    word_t  initial_reg;
    word_t  target_reg;
    word_t  gain_p_reg;
    word_t  gain_i_reg;
    word_t  gain_d_reg;
    uword_t step_reg;
    uword_t tol_reg;

    word_t  plant_reg;
    word_t  esum_reg;
    word_t  last_reg;
    word_t  err_reg;
    prod_t  prod_reg;
    logic   prod_neg_reg;
    word_t  acc_reg;
    word_t  slope_reg;
    word_t  drive_reg;
    word_t  plant_out_reg;
    word_t  offset_out_reg;
    word_t  slope_out_reg;
    word_t  drive_out_reg;
    logic   settled_out_reg;

    word_t  offset;
    logic   in_band;
    word_t  diff;
    word_t  quot;
    logic   div_busy;
    word_t  mul_a;
    word_t  mul_b;
    logic   mul_neg;
    prod_t  prod_c;
    word_t  scaled;

    assign offset  = sat_sub(plant_reg, target_reg);
    assign in_band = mag(offset) <= {1'b0, tol_reg};
    assign diff    = sat_sub(err_reg, last_reg);
    assign scaled  = sat_mag(prod_reg >> FRAC_W, prod_neg_reg);

    pcls_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.op == OP_DIFF),
        .num_mag (mag(diff)),
        .num_neg (diff[DATA_W-1]),
        .divisor (step_reg),
        .busy    (div_busy),
        .quot    (quot)
    );

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (cmd.op)
            OP_MUL_EDT: begin
                mul_a   = mag(err_reg);
                mul_b   = {1'b0, step_reg};
                mul_neg = err_reg[DATA_W-1];
            end
            OP_MUL_P: begin
                mul_a   = mag(gain_p_reg);
                mul_b   = mag(err_reg);
                mul_neg = gain_p_reg[DATA_W-1] ^ err_reg[DATA_W-1];
            end
            OP_MUL_I: begin
                mul_a   = mag(gain_i_reg);
                mul_b   = mag(esum_reg);
                mul_neg = gain_i_reg[DATA_W-1] ^ esum_reg[DATA_W-1];
            end
            OP_MUL_D: begin
                mul_a   = mag(gain_d_reg);
                mul_b   = mag(quot);
                mul_neg = gain_d_reg[DATA_W-1] ^ quot[DATA_W-1];
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    assign prod_c = {{DATA_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            initial_reg <= RST_INITIAL;
            target_reg  <= RST_TARGET;
            gain_p_reg  <= RST_GAIN_P;
            gain_i_reg  <= RST_GAIN_I;
            gain_d_reg  <= RST_GAIN_D;
            step_reg    <= RST_STEP;
            tol_reg     <= RST_TOL;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                REG_INITIAL: initial_reg <= cfg_data;
                REG_TARGET:  target_reg  <= cfg_data;
                REG_GAIN_P:  gain_p_reg  <= cfg_data;
                REG_GAIN_I:  gain_i_reg  <= cfg_data;
                REG_GAIN_D:  gain_d_reg  <= cfg_data;
                REG_STEP:    step_reg    <= cfg_data[UDATA_W-1:0];
                REG_TOL:     tol_reg     <= cfg_data[UDATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            plant_reg <= '0;
            esum_reg  <= '0;
            last_reg  <= '0;
        end
        else begin
            unique case (cmd.op)
                OP_LOAD: begin
                    plant_reg <= initial_reg;
                    esum_reg  <= '0;
                    last_reg  <= '0;
                end
                OP_ACC_ESUM: esum_reg <= sat_add(esum_reg, scaled);
                OP_UPDATE: begin
                    plant_reg <= sat_add(plant_reg, drive_reg);
                    last_reg  <= err_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        unique case (cmd.op)
            OP_LOAD, OP_HOLD: begin
                slope_reg <= '0;
                drive_reg <= '0;
            end
            OP_ERR: err_reg <= sat_sub(target_reg, plant_reg);
            OP_MUL_EDT, OP_MUL_P, OP_MUL_I: begin
                prod_reg     <= prod_c;
                prod_neg_reg <= mul_neg;
            end
            OP_MUL_D: begin
                prod_reg     <= prod_c;
                prod_neg_reg <= mul_neg;
                slope_reg    <= quot;
            end
            OP_ACC_P: acc_reg <= scaled;
            OP_ACC_I: acc_reg <= sat_add(acc_reg, scaled);
            OP_ACC_D: drive_reg <= sat_add(acc_reg, scaled);
            OP_CAPTURE: begin
                plant_out_reg   <= plant_reg;
                offset_out_reg  <= offset;
                slope_out_reg   <= slope_reg;
                drive_out_reg   <= drive_reg;
                settled_out_reg <= in_band;
            end
            default: ;
        endcase
    end

    assign status.settled  = in_band;
    assign status.div_busy = div_busy;

    assign plant_q   = plant_out_reg;
    assign offset_q  = offset_out_reg;
    assign slope_q   = slope_out_reg;
    assign drive_q   = drive_out_reg;
    assign settled_q = settled_out_reg;

endmodule

FILE: rtl/core/pcls_ctrl.sv
module pcls_ctrl
    import pcls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_stall,
    input  logic       restart,
    output logic       result_valid,
    input  logic       result_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIFF,
        S_MUL_EDT,
        S_ACC_ESUM,
        S_MUL_P,
        S_ACC_P,
        S_MUL_I,
        S_ACC_I,
        S_WAIT_DIV,
        S_MUL_D,
        S_ACC_D,
        S_UPDATE,
        S_CAPTURE
    } state_t;

    state_t state_reg;
    logic   restart_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_CHECK: begin
                if (restart_reg)
                    cmd.op = OP_LOAD;
                else if (status.settled)
                    cmd.op = OP_HOLD;
                else
                    cmd.op = OP_ERR;
            end
            S_DIFF:     cmd.op = OP_DIFF;
            S_MUL_EDT:  cmd.op = OP_MUL_EDT;
            S_ACC_ESUM: cmd.op = OP_ACC_ESUM;
            S_MUL_P:    cmd.op = OP_MUL_P;
            S_ACC_P:    cmd.op = OP_ACC_P;
            S_MUL_I:    cmd.op = OP_MUL_I;
            S_ACC_I:    cmd.op = OP_ACC_I;
            S_MUL_D:    cmd.op = OP_MUL_D;
            S_ACC_D:    cmd.op = OP_ACC_D;
            S_UPDATE:   cmd.op = OP_UPDATE;
            S_CAPTURE:  cmd.op = out_free ? OP_CAPTURE : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (state_reg == S_CAPTURE && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (tick_valid) begin
                        restart_reg <= restart;
                        state_reg   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (restart_reg || status.settled)
                        state_reg <= S_CAPTURE;
                    else
                        state_reg <= S_DIFF;
                end
                S_DIFF:     state_reg <= S_MUL_EDT;
                S_MUL_EDT:  state_reg <= S_ACC_ESUM;
                S_ACC_ESUM: state_reg <= S_MUL_P;
                S_MUL_P:    state_reg <= S_ACC_P;
                S_ACC_P:    state_reg <= S_MUL_I;
                S_MUL_I:    state_reg <= S_ACC_I;
                S_ACC_I:    state_reg <= S_WAIT_DIV;
                S_WAIT_DIV: begin
                    if (!status.div_busy)
                        state_reg <= S_MUL_D;
                end
                S_MUL_D:    state_reg <= S_ACC_D;
                S_ACC_D:    state_reg <= S_UPDATE;
                S_UPDATE:   state_reg <= S_CAPTURE;
                S_CAPTURE: begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    assign tick_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> state_reg == S_CHECK)
        else $error("request accepted without entering check");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |=> status.div_busy)
        else $error("divider not busy after start");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_D) |-> !status.div_busy)
        else $error("derivative used before divide finished");

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAPTURE && out_free) |=> (result_valid && state_reg == S_IDLE))
        else $error("capture did not present result");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
    import pcls_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD = 300;
    localparam int REPORT_MAX = 10;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -WORD_HI - 64'sd1;

    typedef struct {
        logic [DATA_W-1:0] plant;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] slope;
        logic [DATA_W-1:0] drive;
        logic              settled;
    } loop_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     tick_valid;
    logic                     tick_stall;
    logic                     restart;
    logic                     result_valid;
    logic                     result_stall;
    logic signed [DATA_W-1:0] plant_out;
    logic signed [DATA_W-1:0] offset_out;
    logic signed [DATA_W-1:0] slope_out;
    logic signed [DATA_W-1:0] drive_out;
    logic                     settled;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    logic [DATA_W-1:0] loop_regs [0:6];
    longint            loop_plant;
    longint            loop_isum;
    longint            loop_prev_err;
    loop_result_t      loop_expected [$];

    int mismatch_cnt;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_left;
    int quiet_cycles;

    pid_closed_loop_step u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .restart      (restart),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .plant_out    (plant_out),
        .offset_out   (offset_out),
        .slope_out    (slope_out),
        .drive_out    (drive_out),
        .settled      (settled),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_HI)
            return WORD_HI;
        if (v < WORD_LO)
            return WORD_LO;
        return v;
    endfunction

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint reg_s(input logic [IDX_W-1:0] idx);
        return longint'(signed'(loop_regs[idx]));
    endfunction

    function automatic longint reg_u(input logic [IDX_W-1:0] idx);
        return longint'(loop_regs[idx][UDATA_W-1:0]);
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        ma = mag_of(a);
        mb = mag_of(b);
        p = (ma * mb) >> FRAC_W;
        return clamp_word(((a < 0) != (b < 0)) ? -longint'(p) : longint'(p));
    endfunction

    // divisor is the time step, never negative
    function automatic longint q_div(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned q;
        ma = mag_of(a);
        if (ma == 0)
            return 0;
        if (b == 0)
            return (a < 0) ? WORD_LO : WORD_HI;
        q = (ma << FRAC_W) / longint'(b);
        return clamp_word((a < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic loop_result_t advance_loop(input logic restart_req);
        longint target;
        longint tol;
        longint dt;
        longint err;
        longint slope;
        longint drive;
        longint offset;
        loop_result_t r;
        target = reg_s(REG_TARGET);
        tol = reg_u(REG_TOL);
        slope = 0;
        drive = 0;
        if (restart_req)
        begin
            loop_plant = reg_s(REG_INITIAL);
            loop_isum = 0;
            loop_prev_err = 0;
        end
        else if (mag_of(clamp_word(loop_plant - target)) > tol)
        begin
            dt = reg_u(REG_STEP);
            err = clamp_word(target - loop_plant);
            loop_isum = clamp_word(loop_isum + q_mul(err, dt));
            slope = q_div(clamp_word(err - loop_prev_err), dt);
            drive = clamp_word(q_mul(reg_s(REG_GAIN_P), err)
                               + q_mul(reg_s(REG_GAIN_I), loop_isum));
            drive = clamp_word(drive + q_mul(reg_s(REG_GAIN_D), slope));
            loop_plant = clamp_word(loop_plant + drive);
            loop_prev_err = err;
        end
        offset = clamp_word(loop_plant - target);
        r.plant = loop_plant[DATA_W-1:0];
        r.offset = offset[DATA_W-1:0];
        r.slope = slope[DATA_W-1:0];
        r.drive = drive[DATA_W-1:0];
        r.settled = (mag_of(offset) <= tol);
        return r;
    endfunction

    // all tasks below start and end at a falling edge
    task automatic send_tick(input logic restart_req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_valid = 1'b0;
            restart = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        tick_valid = 1'b1;
        restart = restart_req;
        do
            @(posedge clk);
        while (tick_stall);
        loop_expected.push_back(advance_loop(restart_req));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        tick_valid = 1'b0;
        while (loop_expected.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_TOL)
            loop_regs[idx] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [DATA_W-1:0] init_v, input logic [DATA_W-1:0] tgt_v,
                             input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                             input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] dt,
                             input logic [DATA_W-1:0] tol);
        write_reg(REG_INITIAL, init_v);
        write_reg(REG_TARGET, tgt_v);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_STEP, dt);
        write_reg(REG_TOL, tol);
    endtask

    // tame settings mostly converge and settle; wild ones exercise saturation
    task automatic load_random_config(input bit wild);
        if (wild)
            write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            write_all($urandom_range(0, 13107200) - 6553600,
                      $urandom_range(0, 13107200) - 6553600,
                      $urandom_range(3277, 65536), $urandom_range(0, 13107),
                      $urandom_range(0, 6554), $urandom_range(655, 65536),
                      $urandom_range(0, 65536));
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, $urandom);
    endtask

    task automatic test_power_on_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (6)
            send_tick(1'b0);
        wait_drained();
    endtask

    task automatic test_corner_settings();
        write_all(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 32'd1, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_drained();
        write_all(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 32'hffff_ffff, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_drained();
        // zero time step, also with only the unused top bit set
        write_all(32'd0, 32'd65536, 32'd6554, 32'd6554, 32'd6554, 32'd0, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_drained();
        write_reg(REG_STEP, 32'h8000_0000);
        send_tick(1'b0);
        wait_drained();
        write_reg(REG_TOL, 32'hffff_ffff);
        send_tick(1'b0);
        wait_drained();
        // exactly on target with a zero band
        write_all(32'h0001_2345, 32'h0001_2345, 32'd6554, 32'd6554, 32'd6554, 32'd6554, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        write_reg(REG_UNUSED, 32'h0000_0000);
        send_tick(1'b0);
        wait_drained();
    endtask

    task automatic test_random_loops(input int total, input int s_pct, input int r_pct);
        int sent;
        int len;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < total)
        begin
            load_random_config($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 99) < 85)
            begin
                send_tick(1'b1);
                sent++;
            end
            len = $urandom_range(10, 60);
            repeat (len)
                send_tick($urandom_range(0, 19) == 0);
            sent += len;
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random_config(1'b0);
        recv_hold_left = LONG_HOLD;
        send_tick(1'b1);
        repeat (11)
            send_tick(1'b0);
        wait_drained();
        repeat (8)
            send_tick($urandom_range(0, 7) == 0);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        tick_valid = 1'b0;
        restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 34;
        recv_idle_pct = 51;
        recv_hold_left = 0;
        loop_regs[REG_INITIAL] = RST_INITIAL;
        loop_regs[REG_TARGET] = RST_TARGET;
        loop_regs[REG_GAIN_P] = RST_GAIN_P;
        loop_regs[REG_GAIN_I] = RST_GAIN_I;
        loop_regs[REG_GAIN_D] = RST_GAIN_D;
        loop_regs[REG_STEP] = {1'b0, RST_STEP};
        loop_regs[REG_TOL] = {1'b0, RST_TOL};
        loop_plant = 0;
        loop_isum = 0;
        loop_prev_err = 0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_power_on_defaults();
        test_corner_settings();
        test_random_loops(380, 34, 51);
        test_random_loops(380, 51, 34);
        test_random_loops(380, 0, 0);
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_cnt == 0 && loop_expected.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold_left > 0)
            begin
                result_stall = 1'b1;
                recv_hold_left--;
            end
            else
                result_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        loop_result_t e;
        mismatch_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (loop_expected.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("unexpected result: plant %0d offset %0d",
                                 plant_out, offset_out);
                end
                else
                begin
                    e = loop_expected.pop_front();
                    if (plant_out !== e.plant || offset_out !== e.offset
                        || slope_out !== e.slope || drive_out !== e.drive
                        || settled !== e.settled)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                        begin
                            $write("mismatch exp/act: plant %0d/%0d offset %0d/%0d ",
                                   signed'(e.plant), plant_out,
                                   signed'(e.offset), offset_out);
                            $display("slope %0d/%0d drive %0d/%0d settled %0b/%0b",
                                     signed'(e.slope), slope_out,
                                     signed'(e.drive), drive_out, e.settled, settled);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((tick_valid && !tick_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

endmodule
